### rtl/core/aeck_pkg.sv
// ----------------------------------------------------------------------------
// aeck_pkg
// Types and constants shared by the alpha edge colour keyer modules.
// ----------------------------------------------------------------------------
package aeck_pkg;

    localparam int CH_BITS       = 8;
    localparam int MEAN_BITS     = 16;
    localparam int FRAC_BITS     = 8;
    localparam int SQ_BITS       = 2 * MEAN_BITS;
    localparam int DIST_BITS     = SQ_BITS + 2;
    localparam int THR_BITS      = 35;
    localparam int DIV_STEP_BITS = $clog2(MEAN_BITS);
    localparam int ACT_BITS      = 2;
    localparam int CFG_IDX_BITS  = 2;

    localparam logic [ACT_BITS-1:0] ACT_ESTIMATE = 2'd0;
    localparam logic [ACT_BITS-1:0] ACT_KEY      = 2'd1;
    localparam logic [ACT_BITS-1:0] ACT_FINISH   = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KEY_RED   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KEY_GREEN = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KEY_BLUE  = 2'd3;

    localparam logic [DIV_STEP_BITS-1:0] DIV_LAST_STEP = DIV_STEP_BITS'(MEAN_BITS - 1);

    typedef enum logic [1:0] {
        S_RUN,
        S_DIV,
        S_STORE
    } t_state;

    typedef struct packed {
        logic est_en;
        logic key_en;
        logic out_load;
        logic fin_zero;
        logic div_load;
        logic div_step;
        logic div_store;
    } t_ctrl_cmd;

    typedef struct packed {
        logic count_zero;
    } t_dp_status;

endpackage

### rtl/core/aeck_ctrl.sv
// ----------------------------------------------------------------------------
// aeck_ctrl
// Handshake control, key pipeline valids and divide sequencing.
// ----------------------------------------------------------------------------
module aeck_ctrl
    import aeck_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [ACT_BITS-1:0] i_action,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  t_dp_status          i_status,
    output t_ctrl_cmd           o_cmd
);

    t_state                   r_state, n_state;
    logic [DIV_STEP_BITS-1:0] r_step, n_step;
    logic                     r_a_valid, n_a_valid;
    logic                     r_out_valid, n_out_valid;

    logic out_free;
    logic accept;
    logic fin;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_RUN) && (!r_a_valid || out_free);
    assign accept     = i_in_valid && o_in_ready;
    assign fin        = accept && (i_action == ACT_FINISH);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            S_RUN: begin
                n_step = '0;
                if (fin && !i_status.count_zero) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_step = r_step + DIV_STEP_BITS'(1);
                if (r_step == DIV_LAST_STEP) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                n_state = S_RUN;
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.est_en    = accept && (i_action == ACT_ESTIMATE);
        o_cmd.key_en    = accept && (i_action == ACT_KEY);
        o_cmd.out_load  = r_a_valid && out_free;
        o_cmd.fin_zero  = fin && i_status.count_zero;
        o_cmd.div_load  = fin && !i_status.count_zero;
        unique case (r_state)
            S_RUN:   ;
            S_DIV:   o_cmd.div_step  = 1'b1;
            S_STORE: o_cmd.div_store = 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        n_a_valid = r_a_valid;
        if (o_cmd.key_en) begin
            n_a_valid = 1'b1;
        end else if (out_free) begin
            n_a_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_step      <= '0;
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_a_valid   <= n_a_valid;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### rtl/core/aeck_datapath.sv
// ----------------------------------------------------------------------------
// aeck_datapath
// Edge sums, mean divider lanes, distance pipeline and output register.
// ----------------------------------------------------------------------------
module aeck_datapath
    import aeck_pkg::*;
#(
    parameter int PCB = 22
)(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ctrl_cmd               i_cmd,
    output t_dp_status              o_status,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [THR_BITS-1:0]     i_cfg_data,
    input  logic [CH_BITS-1:0]      i_red,
    input  logic [CH_BITS-1:0]      i_green,
    input  logic [CH_BITS-1:0]      i_blue,
    input  logic [CH_BITS-1:0]      i_alpha,
    input  logic                    i_row_start,
    output logic [CH_BITS-1:0]      o_red,
    output logic [CH_BITS-1:0]      o_green,
    output logic [CH_BITS-1:0]      o_blue,
    output logic [CH_BITS-1:0]      o_alpha,
    output logic                    o_keyed
);

    localparam int SUM_BITS = PCB + CH_BITS;
    localparam int NUM_BITS = PCB + MEAN_BITS;

    logic [THR_BITS-1:0]  r_thr;
    logic [CH_BITS-1:0]   r_key [3];
    logic [CH_BITS-1:0]   r_prev_colour [3];
    logic                 r_prev_opaque;
    logic                 r_prev_present;
    logic [SUM_BITS-1:0]  r_sum [3];
    logic [PCB-1:0]       r_count;
    logic [MEAN_BITS-1:0] r_mean [3];
    logic                 r_mean_valid;

    logic [PCB-1:0]       r_rem [3];
    logic [MEAN_BITS-1:0] r_quo [3];

    logic [CH_BITS-1:0]   r_a_colour [3];
    logic [CH_BITS-1:0]   r_a_alpha;
    logic [SQ_BITS-1:0]   r_a_sq [3];
    logic                 r_a_mean_valid;

    logic [CH_BITS-1:0]   r_o_colour [3];
    logic [CH_BITS-1:0]   r_o_alpha;
    logic                 r_o_keyed;

    logic [CH_BITS-1:0]   in_colour [3];
    logic                 opaque;
    logic                 add_edge;
    logic [CH_BITS-1:0]   edge_colour [3];
    logic [NUM_BITS-1:0]  numer [3];
    logic [PCB:0]         trial [3];
    logic [PCB:0]         diff [3];
    logic [MEAN_BITS-1:0] scaled [3];
    logic [MEAN_BITS-1:0] dist_abs [3];
    logic [DIST_BITS-1:0] dist_sum;
    logic                 hit;

    assign in_colour[0] = i_red;
    assign in_colour[1] = i_green;
    assign in_colour[2] = i_blue;

    assign o_status.count_zero = (r_count == '0);

    assign opaque   = (i_alpha != '0);
    assign add_edge = r_prev_present && !i_row_start && (r_prev_opaque != opaque)
                      && !(&r_count);

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            edge_colour[c] = opaque ? in_colour[c] : r_prev_colour[c];
            numer[c]  = {r_sum[c], {FRAC_BITS{1'b0}}}
                        + {{(MEAN_BITS + 1){1'b0}}, r_count[PCB-1:1]};
            trial[c]  = {r_rem[c], r_quo[c][MEAN_BITS-1]};
            diff[c]   = trial[c] - {1'b0, r_count};
            scaled[c] = {in_colour[c], {FRAC_BITS{1'b0}}};
            dist_abs[c] = (scaled[c] >= r_mean[c]) ? (scaled[c] - r_mean[c])
                                                   : (r_mean[c] - scaled[c]);
        end
        dist_sum = {2'b00, r_a_sq[0]} + {2'b00, r_a_sq[1]} + {2'b00, r_a_sq[2]};
        hit      = r_a_mean_valid && ({1'b0, dist_sum} < r_thr);
    end

    // configuration and estimate state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr          <= '0;
            r_prev_opaque  <= 1'b0;
            r_prev_present <= 1'b0;
            r_count        <= '0;
            r_mean_valid   <= 1'b0;
            for (int c = 0; c < 3; c++) begin
                r_key[c]         <= '0;
                r_prev_colour[c] <= '0;
                r_sum[c]         <= '0;
                r_mean[c]        <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_THRESHOLD: r_thr    <= i_cfg_data;
                    CFG_KEY_RED:   r_key[0] <= i_cfg_data[CH_BITS-1:0];
                    CFG_KEY_GREEN: r_key[1] <= i_cfg_data[CH_BITS-1:0];
                    CFG_KEY_BLUE:  r_key[2] <= i_cfg_data[CH_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.est_en) begin
                if (add_edge) begin
                    r_count <= r_count + {{(PCB-1){1'b0}}, 1'b1};
                    for (int c = 0; c < 3; c++) begin
                        r_sum[c] <= r_sum[c] + {{PCB{1'b0}}, edge_colour[c]};
                    end
                end
                for (int c = 0; c < 3; c++) begin
                    r_prev_colour[c] <= in_colour[c];
                end
                r_prev_opaque  <= opaque;
                r_prev_present <= 1'b1;
            end
            if (i_cmd.fin_zero || i_cmd.div_load) begin
                r_prev_present <= 1'b0;
            end
            if (i_cmd.fin_zero) begin
                r_mean_valid <= 1'b0;
            end
            if (i_cmd.div_store) begin
                r_mean_valid <= 1'b1;
                r_count      <= '0;
                for (int c = 0; c < 3; c++) begin
                    r_mean[c] <= r_quo[c];
                    r_sum[c]  <= '0;
                end
            end
        end
    end

    // restoring divider lanes, one quotient bit per step
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            if (i_cmd.div_load) begin
                r_rem[c] <= numer[c][NUM_BITS-1:MEAN_BITS];
                r_quo[c] <= numer[c][MEAN_BITS-1:0];
            end else if (i_cmd.div_step) begin
                if (!diff[c][PCB]) begin
                    r_rem[c] <= diff[c][PCB-1:0];
                    r_quo[c] <= {r_quo[c][MEAN_BITS-2:0], 1'b1};
                end else begin
                    r_rem[c] <= trial[c][PCB-1:0];
                    r_quo[c] <= {r_quo[c][MEAN_BITS-2:0], 1'b0};
                end
            end
        end
    end

    // key pipeline: squares, then compare into the output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.key_en) begin
            for (int c = 0; c < 3; c++) begin
                r_a_colour[c] <= in_colour[c];
                r_a_sq[c]     <= dist_abs[c] * dist_abs[c];
            end
            r_a_alpha      <= i_alpha;
            r_a_mean_valid <= r_mean_valid;
        end
        if (i_cmd.out_load) begin
            for (int c = 0; c < 3; c++) begin
                r_o_colour[c] <= hit ? r_key[c] : r_a_colour[c];
            end
            r_o_alpha <= r_a_alpha;
            r_o_keyed <= hit;
        end
    end

    assign o_red   = r_o_colour[0];
    assign o_green = r_o_colour[1];
    assign o_blue  = r_o_colour[2];
    assign o_alpha = r_o_alpha;
    assign o_keyed = r_o_keyed;

endmodule

### rtl/core/alpha_edge_colour_keyer.sv
// ----------------------------------------------------------------------------
// alpha_edge_colour_keyer
// Background colour estimate from alpha edges and colour keying against it.
//
// Input stream words carry an RGBA pixel in tdata and the action code and
// row start flag in tuser. Estimate words accumulate the colour of the opaque
// side of every transparent/opaque pair within a row until the edge count
// saturates; they produce no output. A finish word divides the sums by the
// edge count into an 8.8 mean with three restoring divider lanes, one quotient
// bit per cycle: the block is busy after the finish word through 16 divide
// steps and one store, or not at all when no edge was seen. Key words produce
// one output word each, through the squares register and then the compare into
// the output register. Estimate and key words are taken one per cycle while no
// divide is running and the square stage can move on. A stalled output holds
// the output register; the input keeps accepting while the square stage is
// empty or can move on. The config channel is always ready and must only be
// written while the block is idle. Reset clears the sums, count, mean, keys and threshold.
// ----------------------------------------------------------------------------
module alpha_edge_colour_keyer
    import aeck_pkg::*;
#(
    parameter int PIXEL_COUNT_BITS = 22
)(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [31:0]             s_axis_tdata,  // red, green, blue, alpha
    input  logic [2:0]              s_axis_tuser,  // action[1:0], row_start
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [31:0]             m_axis_tdata,  // out_red, out_green, out_blue, out_alpha
    output logic [0:0]              m_axis_tuser,  // keyed
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [THR_BITS-1:0]     i_cfg_data
);

    t_ctrl_cmd  cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    aeck_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_action    (s_axis_tuser[1:0]),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    aeck_datapath #(
        .PCB (PIXEL_COUNT_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_red       (s_axis_tdata[7:0]),
        .i_green     (s_axis_tdata[15:8]),
        .i_blue      (s_axis_tdata[23:16]),
        .i_alpha     (s_axis_tdata[31:24]),
        .i_row_start (s_axis_tuser[2]),
        .o_red       (m_axis_tdata[7:0]),
        .o_green     (m_axis_tdata[15:8]),
        .o_blue      (m_axis_tdata[23:16]),
        .o_alpha     (m_axis_tdata[31:24]),
        .o_keyed     (m_axis_tuser[0])
    );

endmodule
